@@ rtl/fsps_pkg.sv @@
// ----------------------------------------------------------------------------
// fsps_pkg
// Shared constants, codes and types of the frame store pixel sampler.
// ----------------------------------------------------------------------------
package fsps_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;

  localparam int COORD_W = 18;
  localparam int INT_W   = COORD_W - FRAC_BITS;
  localparam int DIVD_W  = INT_W - 1;
  localparam int DIM_W   = 9;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int X_W     = $clog2(MAX_WIDTH);
  localparam int Y_W     = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = X_W + Y_W;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int WT_W    = FRAC_BITS + 1;
  localparam int W2_W    = 2 * FRAC_BITS + 1;
  localparam int ACC_W   = CH_W + 2 * FRAC_BITS;
  localparam int STEP_W  = $clog2(DIVD_W);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE  = 2'd2;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  localparam logic [WT_W-1:0] FRAC_ONE = WT_W'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_REM_U,
    ST_WAIT_U,
    ST_REM_V,
    ST_WAIT_V,
    ST_FETCH,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIM_W-1:0]  divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [DIM_W-1:0] rem;
  } rem_rsp_t;

endpackage

@@ rtl/fsps_req_if.sv @@
// ----------------------------------------------------------------------------
// fsps_req_if
// Request channel: pixel writes and sample requests.
// ----------------------------------------------------------------------------
interface fsps_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [fsps_pkg::COORD_W-1:0] x_coord;
  logic signed [fsps_pkg::COORD_W-1:0] y_coord;
  logic [fsps_pkg::CH_W-1:0]           in_blue;
  logic [fsps_pkg::CH_W-1:0]           in_green;
  logic [fsps_pkg::CH_W-1:0]           in_red;

  modport source (output valid, req_type, x_coord, y_coord, in_blue, in_green, in_red,
                  input ready);
  modport sink (input valid, req_type, x_coord, y_coord, in_blue, in_green, in_red,
                output ready);
endinterface

@@ rtl/fsps_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fsps_rsp_if
// Result channel: sampled B, G, R.
// ----------------------------------------------------------------------------
interface fsps_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [fsps_pkg::CH_W-1:0] out_blue;
  logic [fsps_pkg::CH_W-1:0] out_green;
  logic [fsps_pkg::CH_W-1:0] out_red;

  modport source (output valid, out_blue, out_green, out_red, input ready);
  modport sink (input valid, out_blue, out_green, out_red, output ready);
endinterface

@@ rtl/fsps_cfg_if.sv @@
// ----------------------------------------------------------------------------
// fsps_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface fsps_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fsps_pkg::CFG_IDX_W-1:0] index;
  logic [fsps_pkg::DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/fsps_rem_unit.sv @@
// ----------------------------------------------------------------------------
// fsps_rem_unit
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsps_rem_unit (
  input  logic               clk,
  input  logic               rst,
  input  fsps_pkg::rem_req_t req,
  output fsps_pkg::rem_rsp_t rsp
);

  logic                               busy;
  logic                               done;
  logic [fsps_pkg::STEP_W-1:0]        step;
  logic [fsps_pkg::DIVD_W-1:0]        quo;
  logic [fsps_pkg::DIM_W-1:0]         rem;
  logic [fsps_pkg::DIM_W-1:0]         divisor;
  logic [fsps_pkg::DIM_W-1:0]         trial;

  assign trial = {rem[fsps_pkg::DIM_W-2:0], quo[fsps_pkg::DIVD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == '0);
      if (req.start) begin
        busy <= 1'b1;
        step <= fsps_pkg::STEP_W'(fsps_pkg::DIVD_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      quo <= quo << 1;
      if (trial >= divisor) begin
        rem <= trial - divisor;
      end else begin
        rem <= trial;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

@@ rtl/frame_store_pixel_sampler_core.sv @@
// ----------------------------------------------------------------------------
// frame_store_pixel_sampler_core
// RGB frame store with nearest and bilinear sampling, clamp and wrap edges.
// ----------------------------------------------------------------------------
// One item at a time. A pixel write passes through the write state before the
// next ready. In a sample, the edge wrap of x and then of y runs through one
// shared remainder unit at one bit per cycle (9 steps each), and the 1 or 4
// neighbor pixels are then read one per cycle from the single-port frame
// store. A finished result waits in the output register while the next
// request is taken.
module frame_store_pixel_sampler_core (
  input  logic       clk,
  input  logic       rst,
  fsps_cfg_if.sink   cfg,
  fsps_req_if.sink   req,
  fsps_rsp_if.source rsp
);

  fsps_pkg::state_t state, state_next;

  logic [fsps_pkg::DIM_W-1:0] eff_width;
  logic [fsps_pkg::DIM_W-1:0] eff_height;
  logic                       interp_mode;

  logic                              item_write;
  logic signed [fsps_pkg::INT_W-1:0] u;
  logic signed [fsps_pkg::INT_W-1:0] v;
  logic [fsps_pkg::FRAC_BITS-1:0]    fx;
  logic [fsps_pkg::FRAC_BITS-1:0]    fy;
  logic [fsps_pkg::PIX_W-1:0]        wr_pix;
  logic [fsps_pkg::X_W-1:0]          u0, u1;
  logic [fsps_pkg::Y_W-1:0]          v0, v1;
  logic [1:0]                        k;
  logic [1:0]                        last_k;
  logic                              acc_en;
  logic [fsps_pkg::W2_W-1:0]         weight;
  logic [fsps_pkg::ACC_W-1:0]        acc_b, acc_g, acc_r;

  logic [fsps_pkg::PIX_W-1:0] mem [fsps_pkg::DEPTH];
  logic [fsps_pkg::PIX_W-1:0] rd_pix;
  logic [fsps_pkg::ADDR_W-1:0] addr;
  logic                        mem_we;

  fsps_pkg::rem_req_t rem_req;
  fsps_pkg::rem_rsp_t rem_rsp;

  logic req_xfer, out_load, write_ok;
  logic [fsps_pkg::X_W:0] ru_inc;
  logic [fsps_pkg::Y_W:0] rv_inc;
  logic [fsps_pkg::WT_W-1:0] wx, wy;

  // Configuration: hold effective sizes and the interpolation mode
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_width   <= fsps_pkg::DIM_W'(fsps_pkg::MAX_WIDTH);
      eff_height  <= fsps_pkg::DIM_W'(fsps_pkg::MAX_HEIGHT);
      interp_mode <= fsps_pkg::MODE_NEAREST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        fsps_pkg::CFG_IMAGE_WIDTH: begin
          if (cfg.data == '0) begin
            eff_width <= fsps_pkg::DIM_W'(1);
          end else if (cfg.data > fsps_pkg::DIM_W'(fsps_pkg::MAX_WIDTH)) begin
            eff_width <= fsps_pkg::DIM_W'(fsps_pkg::MAX_WIDTH);
          end else begin
            eff_width <= cfg.data;
          end
        end
        fsps_pkg::CFG_IMAGE_HEIGHT: begin
          if (cfg.data == '0) begin
            eff_height <= fsps_pkg::DIM_W'(1);
          end else if (cfg.data > fsps_pkg::DIM_W'(fsps_pkg::MAX_HEIGHT)) begin
            eff_height <= fsps_pkg::DIM_W'(fsps_pkg::MAX_HEIGHT);
          end else begin
            eff_height <= cfg.data;
          end
        end
        fsps_pkg::CFG_INTERP_MODE: interp_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Shared remainder unit
  fsps_rem_unit u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      fsps_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = (req.req_type == fsps_pkg::REQ_WRITE) ? fsps_pkg::ST_WRITE
                                                               : fsps_pkg::ST_REM_U;
        end
      end
      fsps_pkg::ST_WRITE:  state_next = fsps_pkg::ST_IDLE;
      fsps_pkg::ST_REM_U:  state_next = fsps_pkg::ST_WAIT_U;
      fsps_pkg::ST_WAIT_U: if (rem_rsp.done) state_next = fsps_pkg::ST_REM_V;
      fsps_pkg::ST_REM_V:  state_next = fsps_pkg::ST_WAIT_V;
      fsps_pkg::ST_WAIT_V: if (rem_rsp.done) state_next = fsps_pkg::ST_FETCH;
      fsps_pkg::ST_FETCH:  if (k == last_k) state_next = fsps_pkg::ST_DRAIN;
      fsps_pkg::ST_DRAIN:  state_next = fsps_pkg::ST_DONE;
      fsps_pkg::ST_DONE:   if (!rsp.valid || rsp.ready) state_next = fsps_pkg::ST_IDLE;
      default:             state_next = fsps_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req.ready        = (state == fsps_pkg::ST_IDLE);
    rem_req.start    = (state == fsps_pkg::ST_REM_U) || (state == fsps_pkg::ST_REM_V);
    rem_req.dividend = '0;
    rem_req.divisor  = eff_width;
    mem_we           = (state == fsps_pkg::ST_WRITE) && write_ok;
    out_load         = (state == fsps_pkg::ST_DONE) && (!rsp.valid || rsp.ready);
    addr             = {v0, u0};
    case (state)
      fsps_pkg::ST_REM_U: begin
        rem_req.dividend = u[fsps_pkg::INT_W-1] ? '0 : u[fsps_pkg::DIVD_W-1:0];
        rem_req.divisor  = eff_width;
      end
      fsps_pkg::ST_REM_V: begin
        rem_req.dividend = v[fsps_pkg::INT_W-1] ? '0 : v[fsps_pkg::DIVD_W-1:0];
        rem_req.divisor  = eff_height;
      end
      fsps_pkg::ST_WRITE: begin
        addr = {v[fsps_pkg::Y_W-1:0], u[fsps_pkg::X_W-1:0]};
      end
      fsps_pkg::ST_FETCH: begin
        addr = {(k[1] ? v1 : v0), (k[0] ? u1 : u0)};
      end
      default: ;
    endcase
  end

  assign req_xfer = req.valid && req.ready;

  assign write_ok = !u[fsps_pkg::INT_W-1] && !v[fsps_pkg::INT_W-1]
                 && (u[fsps_pkg::DIVD_W-1:0] < eff_width)
                 && (v[fsps_pkg::DIVD_W-1:0] < eff_height);

  // Right and lower neighbors wrap to zero at the active size
  assign ru_inc = {1'b0, u0} + 1'b1;
  assign rv_inc = {1'b0, v0} + 1'b1;

  assign wx = k[0] ? {1'b0, fx} : fsps_pkg::FRAC_ONE - {1'b0, fx};
  assign wy = k[1] ? {1'b0, fy} : fsps_pkg::FRAC_ONE - {1'b0, fy};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= fsps_pkg::ST_IDLE;
      acc_en  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state  <= state_next;
      acc_en <= (state == fsps_pkg::ST_FETCH);
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      item_write <= (req.req_type == fsps_pkg::REQ_WRITE);
      u          <= req.x_coord[fsps_pkg::COORD_W-1:fsps_pkg::FRAC_BITS];
      v          <= req.y_coord[fsps_pkg::COORD_W-1:fsps_pkg::FRAC_BITS];
      fx         <= (interp_mode == fsps_pkg::MODE_BILINEAR)
                    ? req.x_coord[fsps_pkg::FRAC_BITS-1:0] : '0;
      fy         <= (interp_mode == fsps_pkg::MODE_BILINEAR)
                    ? req.y_coord[fsps_pkg::FRAC_BITS-1:0] : '0;
      last_k     <= (interp_mode == fsps_pkg::MODE_BILINEAR) ? 2'd3 : 2'd0;
      wr_pix     <= {req.in_red, req.in_green, req.in_blue};
      k          <= '0;
      acc_b      <= '0;
      acc_g      <= '0;
      acc_r      <= '0;
    end
    if ((state == fsps_pkg::ST_WAIT_U) && rem_rsp.done) begin
      u0 <= u[fsps_pkg::INT_W-1] ? '0 : rem_rsp.rem[fsps_pkg::X_W-1:0];
    end
    if ((state == fsps_pkg::ST_WAIT_V) && rem_rsp.done) begin
      v0 <= v[fsps_pkg::INT_W-1] ? '0 : rem_rsp.rem[fsps_pkg::Y_W-1:0];
    end
    if (state == fsps_pkg::ST_REM_V) begin
      if (u[fsps_pkg::INT_W-1] || (ru_inc == eff_width)) begin
        u1 <= '0;
      end else begin
        u1 <= ru_inc[fsps_pkg::X_W-1:0];
      end
    end
    if (state == fsps_pkg::ST_FETCH) begin
      if (v[fsps_pkg::INT_W-1] || (rv_inc == eff_height)) begin
        v1 <= '0;
      end else begin
        v1 <= rv_inc[fsps_pkg::Y_W-1:0];
      end
    end
    if (state == fsps_pkg::ST_FETCH) begin
      k      <= k + 1'b1;
      weight <= fsps_pkg::W2_W'(wx * wy);
    end
    if (acc_en) begin
      acc_b <= acc_b + fsps_pkg::ACC_W'(rd_pix[fsps_pkg::CH_W-1:0] * weight);
      acc_g <= acc_g + fsps_pkg::ACC_W'(rd_pix[2*fsps_pkg::CH_W-1:fsps_pkg::CH_W] * weight);
      acc_r <= acc_r + fsps_pkg::ACC_W'(rd_pix[3*fsps_pkg::CH_W-1:2*fsps_pkg::CH_W] * weight);
    end
    if (out_load) begin
      rsp.out_blue  <= acc_b[fsps_pkg::ACC_W-1:2*fsps_pkg::FRAC_BITS];
      rsp.out_green <= acc_g[fsps_pkg::ACC_W-1:2*fsps_pkg::FRAC_BITS];
      rsp.out_red   <= acc_r[fsps_pkg::ACC_W-1:2*fsps_pkg::FRAC_BITS];
    end
  end

  // Frame store, single port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wr_pix;
    end else begin
      rd_pix <= mem[addr];
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> ($past(state) == fsps_pkg::ST_DONE) && !item_write)
    else $error("result raised without a finished sample");

  assert property (@(posedge clk) disable iff (rst)
    rem_rsp.done |-> (state == fsps_pkg::ST_WAIT_U) || (state == fsps_pkg::ST_WAIT_V))
    else $error("remainder done outside a wait state");

  assert property (@(posedge clk) disable iff (rst)
    (state == fsps_pkg::ST_FETCH) |-> (k <= last_k))
    else $error("fetch counter ran past the last neighbor");

  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !req.ready && !acc_en)
    else $error("store write collides with a transfer or a read");

endmodule

@@ dv/frame_store_pixel_sampler_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_store_pixel_sampler_core_test
// Self-checking bench for the frame store pixel sampler. Pixel writes and
// sample requests enter through the request channel with random gaps, and
// the result channel stalls at random. A mirror of the frame store predicts
// every nearest and bilinear sample bit for bit. Each returned B,G,R is
// compared with it across a series of image sizes and modes, including zero
// and oversize settings. Samples only touch pixels that have been written.
// ----------------------------------------------------------------------------
module frame_store_pixel_sampler_core_test;

  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 55;
  localparam int FILL_LIMIT    = 64;
  localparam int REPORT_LIMIT  = 100;
  localparam int NUM_PHASES    = 12;
  localparam int SPARE_PHASE   = 4;
  localparam int SCALE         = 1 << fsps_pkg::FRAC_BITS;

  localparam logic [fsps_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic signed [fsps_pkg::COORD_W-1:0] COORD_MIN =
    {1'b1, {(fsps_pkg::COORD_W-1){1'b0}}};
  localparam logic signed [fsps_pkg::COORD_W-1:0] COORD_MAX =
    {1'b0, {(fsps_pkg::COORD_W-1){1'b1}}};

  localparam int PHASE_W [NUM_PHASES] = '{0, 1, 3, 8, 7, 511, 256, 256, 1, 5, 256, 2};
  localparam int PHASE_H [NUM_PHASES] = '{0, 1, 5, 8, 2, 3, 256, 1, 256, 7, 256, 9};
  localparam bit PHASE_M [NUM_PHASES] = '{1, 0, 1, 1, 0, 1, 1, 0, 1, 1, 0, 1};

  typedef struct packed {
    logic [fsps_pkg::CH_W-1:0] red;
    logic [fsps_pkg::CH_W-1:0] green;
    logic [fsps_pkg::CH_W-1:0] blue;
  } pixel_t;

  typedef struct {
    logic                                req_type;
    logic signed [fsps_pkg::COORD_W-1:0] x;
    logic signed [fsps_pkg::COORD_W-1:0] y;
    pixel_t                              color;
  } request_t;

  class frame_mirror;
    pixel_t                     frame [fsps_pkg::DEPTH];
    bit                         written [fsps_pkg::DEPTH];
    logic [fsps_pkg::DIM_W-1:0] width_reg;
    logic [fsps_pkg::DIM_W-1:0] height_reg;
    logic                       mode_reg;
    pixel_t                     sampled_pixels [$];
    int                         stores, dropped, samples, checked, errors;

    function new();
      width_reg  = fsps_pkg::DIM_W'(fsps_pkg::MAX_WIDTH);
      height_reg = fsps_pkg::DIM_W'(fsps_pkg::MAX_HEIGHT);
      mode_reg   = fsps_pkg::MODE_NEAREST;
    endfunction

    function void set_register(logic [fsps_pkg::CFG_IDX_W-1:0] idx,
                               logic [fsps_pkg::DIM_W-1:0] data);
      case (idx)
        fsps_pkg::CFG_IMAGE_WIDTH:  width_reg = data;
        fsps_pkg::CFG_IMAGE_HEIGHT: height_reg = data;
        fsps_pkg::CFG_INTERP_MODE:  mode_reg = data[0];
        default: ;
      endcase
    endfunction

    function int eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > fsps_pkg::MAX_WIDTH) return fsps_pkg::MAX_WIDTH;
      return int'(width_reg);
    endfunction

    function int eff_h();
      if (height_reg == 0) return 1;
      if (height_reg > fsps_pkg::MAX_HEIGHT) return fsps_pkg::MAX_HEIGHT;
      return int'(height_reg);
    endfunction

    // clamp below, wrap above
    function int store_slot(int u, int v);
      int uu, vv;
      uu = (u < 0) ? 0 : u % eff_w();
      vv = (v < 0) ? 0 : v % eff_h();
      return vv * fsps_pkg::MAX_WIDTH + uu;
    endfunction

    function bit sample_safe(logic signed [fsps_pkg::COORD_W-1:0] x,
                             logic signed [fsps_pkg::COORD_W-1:0] y);
      int u, v;
      u = int'(x) >>> fsps_pkg::FRAC_BITS;
      v = int'(y) >>> fsps_pkg::FRAC_BITS;
      if (mode_reg == fsps_pkg::MODE_NEAREST) return written[store_slot(u, v)];
      return written[store_slot(u, v)] && written[store_slot(u + 1, v)] &&
             written[store_slot(u, v + 1)] && written[store_slot(u + 1, v + 1)];
    endfunction

    function pixel_t blend_pixel(logic signed [fsps_pkg::COORD_W-1:0] x,
                                 logic signed [fsps_pkg::COORD_W-1:0] y);
      int     u, v, fx, fy, acc, c;
      pixel_t p00, p10, p01, p11, mix;
      u   = int'(x) >>> fsps_pkg::FRAC_BITS;
      v   = int'(y) >>> fsps_pkg::FRAC_BITS;
      fx  = int'(x[fsps_pkg::FRAC_BITS-1:0]);
      fy  = int'(y[fsps_pkg::FRAC_BITS-1:0]);
      p00 = frame[store_slot(u, v)];
      if (mode_reg == fsps_pkg::MODE_NEAREST) return p00;
      p10 = frame[store_slot(u + 1, v)];
      p01 = frame[store_slot(u, v + 1)];
      p11 = frame[store_slot(u + 1, v + 1)];
      for (c = 0; c < 3; c++) begin
        acc = int'(p00[fsps_pkg::CH_W*c +: fsps_pkg::CH_W]) * (SCALE - fx) * (SCALE - fy)
            + int'(p10[fsps_pkg::CH_W*c +: fsps_pkg::CH_W]) * fx * (SCALE - fy)
            + int'(p01[fsps_pkg::CH_W*c +: fsps_pkg::CH_W]) * (SCALE - fx) * fy
            + int'(p11[fsps_pkg::CH_W*c +: fsps_pkg::CH_W]) * fx * fy;
        mix[fsps_pkg::CH_W*c +: fsps_pkg::CH_W] =
          fsps_pkg::CH_W'(acc >> (2 * fsps_pkg::FRAC_BITS));
      end
      return mix;
    endfunction

    function void note_request(request_t r);
      int u, v, idx;
      u = int'(r.x) >>> fsps_pkg::FRAC_BITS;
      v = int'(r.y) >>> fsps_pkg::FRAC_BITS;
      if (r.req_type == fsps_pkg::REQ_WRITE) begin
        if (u >= 0 && u < eff_w() && v >= 0 && v < eff_h()) begin
          idx          = v * fsps_pkg::MAX_WIDTH + u;
          frame[idx]   = r.color;
          written[idx] = 1'b1;
          stores++;
        end else begin
          dropped++;
        end
      end else begin
        sampled_pixels.push_back(blend_pixel(r.x, r.y));
        samples++;
      end
    endfunction

    function void flag(string field, logic [fsps_pkg::CH_W-1:0] want,
                       logic [fsps_pkg::CH_W-1:0] got);
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (sampled_pixels.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: result with no sample waiting, expected none, actual %06h",
                   $time, got);
        return;
      end
      want = sampled_pixels.pop_front();
      checked++;
      if (got.blue !== want.blue) flag("out_blue", want.blue, got.blue);
      if (got.green !== want.green) flag("out_green", want.green, got.green);
      if (got.red !== want.red) flag("out_red", want.red, got.red);
    endfunction
  endclass

  logic clk;
  logic rst;

  fsps_cfg_if cfg_ch ();
  fsps_req_if req_ch ();
  fsps_rsp_if rsp_ch ();

  frame_store_pixel_sampler_core dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  frame_mirror mirror;
  int          painted [$];
  bit          req_steady;
  bit          rsp_steady;
  int          rsp_hold;

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [fsps_pkg::COORD_W-1:0] fix(int ipart, int f);
    return fsps_pkg::COORD_W'(ipart * SCALE + f);
  endfunction

  function automatic int any_frac();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return SCALE - 1;
      default: return $urandom_range(0, SCALE - 1);
    endcase
  endfunction

  function automatic pixel_t any_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return fsps_pkg::PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [fsps_pkg::COORD_W-1:0] any_coord(int size);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return '0;
          3: return '1;
          4: return fix(size - 1, SCALE - 1);
          default: return fix(size, 0);
        endcase
      end
      1, 2, 3: return fsps_pkg::COORD_W'($urandom);
      default: return fix(int'($urandom_range(0, 2 * size + 3)) - 2, any_frac());
    endcase
  endfunction

  function automatic logic signed [fsps_pkg::COORD_W-1:0] outside_coord(int size);
    if ($urandom_range(0, 1) == 1) return fix(-int'($urandom_range(1, 512)), any_frac());
    return fix($urandom_range(size, 511), any_frac());
  endfunction

  // move a written position to a coordinate that folds back onto it
  function automatic int spread(int c, int size);
    int r;
    r = $urandom_range(0, 9);
    if (c == 0 && r == 0) return -int'($urandom_range(1, 512));
    if (r < 7) return c;
    return c + size * int'($urandom_range(0, (511 - c) / size));
  endfunction

  task automatic send_request(request_t r);
    int gap;
    gap = (req_steady || $urandom_range(0, 9) < 6) ? 0 : stall_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= r.req_type;
    req_ch.x_coord  <= r.x;
    req_ch.y_coord  <= r.y;
    req_ch.in_blue  <= r.color.blue;
    req_ch.in_green <= r.color.green;
    req_ch.in_red   <= r.color.red;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    mirror.note_request(r);
  endtask

  task automatic paint(int u, int v);
    request_t r;
    r.req_type = fsps_pkg::REQ_WRITE;
    r.x        = fix(u, any_frac());
    r.y        = fix(v, any_frac());
    r.color    = any_pixel();
    send_request(r);
    painted.push_back(v * fsps_pkg::MAX_WIDTH + u);
  endtask

  task automatic cfg_write(logic [fsps_pkg::CFG_IDX_W-1:0] idx,
                           logic [fsps_pkg::DIM_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    mirror.set_register(idx, data);
  endtask

  task automatic settle();
    while (mirror.sampled_pixels.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #20ms;
    $display("FAIL frame_store_pixel_sampler_core");
    $finish;
  end

  always @(posedge clk) begin
    if (rsp_hold > 0) begin
      rsp_hold     <= rsp_hold - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!rsp_steady && $urandom_range(0, 3) == 0) begin
      rsp_hold     <= stall_len() - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk)
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      mirror.check_pixel({rsp_ch.out_red, rsp_ch.out_green, rsp_ch.out_blue});

  initial begin : stimulus
    request_t                   r;
    logic [fsps_pkg::DIM_W-1:0] mode_word;
    int                         p, w, h, n, u, v, bx, by, bw, bh, pick, tries, spot;
    bit                         found;

    mirror = new();
    rst             <= 1'b1;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= fsps_pkg::CFG_IMAGE_WIDTH;
    cfg_ch.data     <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= fsps_pkg::REQ_WRITE;
    req_ch.x_coord  <= '0;
    req_ch.y_coord  <= '0;
    req_ch.in_blue  <= '0;
    req_ch.in_green <= '0;
    req_ch.in_red   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners of the full image at reset size, then writes that must drop
    send_request('{fsps_pkg::REQ_WRITE, fix(0, 0), fix(0, 0), '1});
    send_request('{fsps_pkg::REQ_WRITE, fix(255, 'h40), fix(0, 'hff), '0});
    send_request('{fsps_pkg::REQ_WRITE, fix(0, 0), fix(255, 1), any_pixel()});
    send_request('{fsps_pkg::REQ_WRITE, fix(255, 'hff), fix(255, 'h80), any_pixel()});
    painted = '{0, 255, 255 * fsps_pkg::MAX_WIDTH, 255 * fsps_pkg::MAX_WIDTH + 255};
    send_request('{fsps_pkg::REQ_WRITE, fix(fsps_pkg::MAX_WIDTH, 0), fix(3, 0), any_pixel()});
    send_request('{fsps_pkg::REQ_WRITE, fix(-1, 'hff), fix(0, 0), any_pixel()});
    send_request('{fsps_pkg::REQ_WRITE, COORD_MIN, COORD_MAX, any_pixel()});

    send_request('{fsps_pkg::REQ_SAMPLE, fix(0, 'h7f), fix(0, 'hff), '0});
    send_request('{fsps_pkg::REQ_SAMPLE, COORD_MIN, COORD_MIN, '1});
    send_request('{fsps_pkg::REQ_SAMPLE, COORD_MAX, COORD_MAX, any_pixel()});
    send_request('{fsps_pkg::REQ_SAMPLE, fix(255, 0), fix(-3, 'h10), any_pixel()});
    send_request('{fsps_pkg::REQ_SAMPLE, fix(-1, 0), fix(255, 'hff), any_pixel()});
    send_request('{fsps_pkg::REQ_SAMPLE, fix(256, 'h80), fix(511, 0), any_pixel()});
    req_ch.valid <= 1'b0;

    settle();
    cfg_write(fsps_pkg::CFG_INTERP_MODE, fsps_pkg::DIM_W'(fsps_pkg::MODE_BILINEAR));
    cfg_ch.valid <= 1'b0;
    send_request('{fsps_pkg::REQ_SAMPLE, fix(255, 'h80), fix(255, 'h80), any_pixel()});
    send_request('{fsps_pkg::REQ_SAMPLE, fix(-1, 'h80), fix(-1, 'h40), any_pixel()});
    send_request('{fsps_pkg::REQ_SAMPLE, COORD_MAX, COORD_MAX, any_pixel()});
    send_request('{fsps_pkg::REQ_SAMPLE, fix(-200, 0), fix(255, 1), any_pixel()});
    send_request('{fsps_pkg::REQ_SAMPLE, fix(511, 'hff), fix(-1, 0), any_pixel()});
    req_ch.valid <= 1'b0;

    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      mode_word    = fsps_pkg::DIM_W'($urandom);
      mode_word[0] = PHASE_M[p];
      cfg_write(fsps_pkg::CFG_IMAGE_WIDTH, fsps_pkg::DIM_W'(PHASE_W[p]));
      cfg_write(fsps_pkg::CFG_IMAGE_HEIGHT, fsps_pkg::DIM_W'(PHASE_H[p]));
      cfg_write(fsps_pkg::CFG_INTERP_MODE, mode_word);
      if (p == SPARE_PHASE) cfg_write(CFG_UNUSED, fsps_pkg::DIM_W'($urandom));
      cfg_ch.valid <= 1'b0;
      req_steady = ($urandom_range(0, 3) == 0);
      rsp_steady <= ($urandom_range(0, 3) == 0);

      w = mirror.eff_w();
      h = mirror.eff_h();
      if (w * h <= FILL_LIMIT) begin
        for (v = 0; v < h; v++)
          for (u = 0; u < w; u++)
            paint(u, v);
      end else begin
        paint(0, 0);
        paint(w - 1, 0);
        paint(0, h - 1);
        paint(w - 1, h - 1);
        bw = (w < 4) ? w : 4;
        bh = (h < 4) ? h : 4;
        bx = $urandom_range(0, w - bw);
        by = $urandom_range(0, h - bh);
        for (v = by; v < by + bh; v++)
          for (u = bx; u < bx + bw; u++)
            paint(u, v);
      end

      n = 0;
      while (n < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // retry until every pixel the sample reads has been written, else fall back to COORD_MIN
          found = 1'b0;
          for (tries = 0; tries < 40 && !found; tries++) begin
            spot = painted[$urandom_range(0, painted.size() - 1)];
            u    = spot % fsps_pkg::MAX_WIDTH;
            v    = spot / fsps_pkg::MAX_WIDTH;
            if (tries < 30 && $urandom_range(0, 1) == 1 && u < w && v < h) begin
              r.x = fix(spread(u, w), any_frac());
              r.y = fix(spread(v, h), any_frac());
            end else begin
              r.x = any_coord(w);
              r.y = any_coord(h);
            end
            found = mirror.sample_safe(r.x, r.y);
          end
          if (!found) begin
            r.x = COORD_MIN;
            r.y = COORD_MIN;
          end
          r.req_type = fsps_pkg::REQ_SAMPLE;
          r.color    = any_pixel();
          send_request(r);
          n++;
        end else if (pick < 85) begin
          paint($urandom_range(0, w - 1), $urandom_range(0, h - 1));
          n++;
        end else begin
          r.req_type = fsps_pkg::REQ_WRITE;
          r.color    = any_pixel();
          if ($urandom_range(0, 1) == 1) begin
            r.x = outside_coord(w);
            r.y = fsps_pkg::COORD_W'($urandom);
          end else begin
            r.x = fsps_pkg::COORD_W'($urandom);
            r.y = outside_coord(h);
          end
          send_request(r);
        end
      end
      req_ch.valid <= 1'b0;
    end

    settle();
    $display("covered %0d stored and %0d dropped pixel writes, %0d samples, %0d image settings",
             mirror.stores, mirror.dropped, mirror.samples, NUM_PHASES + 2);
    $display("compared %0d results, %0d still waiting, %0d mismatches",
             mirror.checked, mirror.sampled_pixels.size(), mirror.errors);
    if (mirror.errors == 0 && mirror.sampled_pixels.size() == 0) begin
      $display("PASS frame_store_pixel_sampler_core");
    end else begin
      $display("FAIL frame_store_pixel_sampler_core");
    end
    $finish;
  end

endmodule
